### design/ggvc_pkg.sv
// shared types, codes and constants of the go-to-goal velocity controller
package ggvc_pkg;

    // event codes of an input request
    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_STEP  = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;

    // status codes of a result
    localparam logic [1:0] STATUS_INIT       = 2'd0;
    localparam logic [1:0] STATUS_RUNNING    = 2'd1;
    localparam logic [1:0] STATUS_COMPLETED  = 2'd2;
    localparam logic [1:0] STATUS_TERMINATED = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_GOAL_X      = 3'd0;
    localparam logic [2:0] CFG_GOAL_Y      = 3'd1;
    localparam logic [2:0] CFG_ARRIVE      = 3'd2;
    localparam logic [2:0] CFG_SPEED_GAIN  = 3'd3;
    localparam logic [2:0] CFG_TURN_GAIN   = 3'd4;
    localparam logic [2:0] CFG_SPEED_LIMIT = 3'd5;
    localparam logic [2:0] CFG_TURN_LIMIT  = 3'd6;
    localparam logic [2:0] CFG_MODE        = 3'd7;

    // mode register bits
    localparam int unsigned MODE_HOLONOMIC = 0;
    localparam int unsigned MODE_RELATIVE  = 1;

    // reset values
    localparam logic [30:0] ARRIVE_RESET = 31'd6554;
    localparam logic [30:0] UNIT_RESET   = 31'd65536;

    // chain lengths: one root bit per sqrt cell, one quotient bit per divide cell
    localparam int unsigned SQRT_CELLS = 32;
    localparam int unsigned DIV_CELLS  = 31;

    // angle constants
    localparam logic signed [20:0] PI_U16          = 21'sd205887;
    localparam logic signed [18:0] PI_Q13          = 19'sd25736;
    localparam logic signed [18:0] TWO_PI_Q13      = 19'sd51472;
    localparam logic signed [16:0] TURN_THRESH_Q13 = 17'sd2859;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [15:0] pose_heading;
    } ggvc_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               cmd_valid;
        logic               cmd_planar;
        logic signed [31:0] vel_fwd_x;
        logic signed [31:0] vel_side_y;
        logic signed [31:0] turn_rate;
    } ggvc_out_t;

    // data handed along the sqrt / cordic chain
    typedef struct packed {
        logic [62:0]        rem;
        logic [62:0]        root;
        logic signed [34:0] cx;
        logic signed [34:0] cy;
        logic signed [20:0] cz;
        logic               zero;
        logic [1:0]         func;
        logic signed [15:0] th;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
    } ggvc_cell_t;

    // result fields settled before the divide chain
    typedef struct packed {
        logic [1:0]         status;
        logic               cmd_valid;
        logic               cmd_planar;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] rot;
        logic               use_div;
        logic               neg_x;
        logic               neg_y;
    } ggvc_res_t;

    // data handed along the divide chain
    typedef struct packed {
        logic [31:0] d;
        logic [31:0] rem_x;
        logic [30:0] low_x;
        logic [30:0] q_x;
        logic [31:0] rem_y;
        logic [30:0] low_y;
        logic [30:0] q_y;
        ggvc_res_t   res;
    } ggvc_div_t;

    // arctangent of 2^-i in units of 2^-16 rad
    function automatic logic signed [20:0] ggvc_atan(input int unsigned idx);
        logic signed [20:0] val;
        case (idx)
            0:       val = 21'sd51472;
            1:       val = 21'sd30386;
            2:       val = 21'sd16055;
            3:       val = 21'sd8150;
            4:       val = 21'sd4091;
            5:       val = 21'sd2047;
            6:       val = 21'sd1024;
            7:       val = 21'sd512;
            8:       val = 21'sd256;
            9:       val = 21'sd128;
            10:      val = 21'sd64;
            11:      val = 21'sd32;
            12:      val = 21'sd16;
            13:      val = 21'sd8;
            14:      val = 21'sd4;
            15:      val = 21'sd2;
            16:      val = 21'sd1;
            default: val = 21'sd0;
        endcase
        return val;
    endfunction

endpackage

### design/ggvc_cell.sv
// one cell of the sqrt / cordic chain: one root bit and, when CORDIC_ON is set, one vectoring rotation
module ggvc_cell #(
    parameter int unsigned IDX       = 0,
    parameter bit          CORDIC_ON = 1'b1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  ggvc_pkg::ggvc_cell_t in_cell,
    output logic                out_vld,
    output ggvc_pkg::ggvc_cell_t out_cell
);

    localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * IDX);
    localparam logic signed [20:0] ATAN_STEP = ggvc_pkg::ggvc_atan(IDX);

    logic                 vld_reg;
    ggvc_pkg::ggvc_cell_t cell_reg;
    ggvc_pkg::ggvc_cell_t cell_next;
    logic [63:0]          trial;
    logic                 take;
    logic signed [34:0]   sx;
    logic signed [34:0]   sy;

    assign trial = {1'b0, in_cell.root} + SQ_BIT;
    assign take  = {1'b0, in_cell.rem} >= trial;
    assign sx    = in_cell.cx >>> IDX;
    assign sy    = in_cell.cy >>> IDX;

    // sqrt bit decision and, when CORDIC_ON is set, cordic micro-rotation
    always_comb
    begin
        cell_next = in_cell;
        if (take)
        begin
            cell_next.rem  = in_cell.rem - trial[62:0];
            cell_next.root = (in_cell.root >> 1) + SQ_BIT[62:0];
        end
        else
        begin
            cell_next.root = in_cell.root >> 1;
        end
        if (CORDIC_ON)
        begin
            if (in_cell.cy > 35'sd0)
            begin
                cell_next.cx = in_cell.cx + sy;
                cell_next.cy = in_cell.cy - sx;
                cell_next.cz = in_cell.cz + ATAN_STEP;
            end
            else
            begin
                cell_next.cx = in_cell.cx - sy;
                cell_next.cy = in_cell.cy + sx;
                cell_next.cz = in_cell.cz - ATAN_STEP;
            end
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_cell = cell_reg;

endmodule

### design/ggvc_div_cell.sv
// one cell of the divide chain: one quotient bit for the x and y lanes
module ggvc_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_vld,
    input  ggvc_pkg::ggvc_div_t in_div,
    output logic               out_vld,
    output ggvc_pkg::ggvc_div_t out_div
);

    logic                vld_reg;
    ggvc_pkg::ggvc_div_t div_reg;
    ggvc_pkg::ggvc_div_t div_next;
    logic [32:0]         tx;
    logic [32:0]         ty;
    logic [32:0]         dx_diff;
    logic [32:0]         dy_diff;
    logic                ge_x;
    logic                ge_y;

    assign tx      = {in_div.rem_x, in_div.low_x[30]};
    assign ty      = {in_div.rem_y, in_div.low_y[30]};
    assign dx_diff = tx - {1'b0, in_div.d};
    assign dy_diff = ty - {1'b0, in_div.d};
    assign ge_x    = tx >= {1'b0, in_div.d};
    assign ge_y    = ty >= {1'b0, in_div.d};

    // restoring step on both lanes
    always_comb
    begin
        div_next       = in_div;
        div_next.rem_x = ge_x ? dx_diff[31:0] : tx[31:0];
        div_next.rem_y = ge_y ? dy_diff[31:0] : ty[31:0];
        div_next.low_x = {in_div.low_x[29:0], 1'b0};
        div_next.low_y = {in_div.low_y[29:0], 1'b0};
        div_next.q_x   = {in_div.q_x[29:0], ge_x};
        div_next.q_y   = {in_div.q_y[29:0], ge_y};
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_div = div_reg;

endmodule

### design/go_to_goal_velocity_control_unit.sv
// go-to-goal velocity controller: one result per accepted start, step or stop request
// throughput: one request per cycle; the whole pipeline advances together and
// stalls only while the output register holds a result that is not taken
// the 32-cell sqrt/cordic chain and the 31-cell divide chain lie between request and result
// reset: configuration goes to its defaults, origin to zero, pipeline empty
module go_to_goal_velocity_control_unit #(
    parameter int unsigned CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ggvc_pkg::ggvc_in_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ggvc_pkg::ggvc_out_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    // configuration and origin
    logic signed [31:0] goal_x_reg;
    logic signed [31:0] goal_y_reg;
    logic [30:0]        arrive_reg;
    logic [30:0]        speed_gain_reg;
    logic [30:0]        turn_gain_reg;
    logic [30:0]        speed_limit_reg;
    logic [30:0]        turn_limit_reg;
    logic [1:0]         mode_reg;
    logic signed [31:0] origin_x_reg;
    logic signed [31:0] origin_y_reg;

    logic adv;
    logic accept;

    // front stages
    logic signed [33:0] diff_x;
    logic signed [33:0] diff_y;
    logic               s0_vld_reg;
    logic [1:0]         s0_func_reg;
    logic signed [15:0] s0_th_reg;
    logic signed [31:0] s0_dx_reg;
    logic signed [31:0] s0_dy_reg;

    logic signed [34:0] dx35;
    logic signed [34:0] dy35;
    logic [31:0]        s0_ax;
    logic [31:0]        s0_ay;
    logic               s1_vld_reg;
    logic [61:0]        s1_sqx_reg;
    logic [61:0]        s1_sqy_reg;
    logic signed [34:0] s1_cx_reg;
    logic signed [34:0] s1_cy_reg;
    logic signed [20:0] s1_cz_reg;
    logic               s1_zero_reg;
    logic [1:0]         s1_func_reg;
    logic signed [15:0] s1_th_reg;
    logic signed [31:0] s1_dx_reg;
    logic signed [31:0] s1_dy_reg;

    logic                 s2_vld_reg;
    ggvc_pkg::ggvc_cell_t s2_cell_reg;

    ggvc_pkg::ggvc_cell_t cell_link [0:ggvc_pkg::SQRT_CELLS];
    logic                 cell_vld  [0:ggvc_pkg::SQRT_CELLS];

    // heading error and distance stage
    ggvc_pkg::ggvc_cell_t last_cell;
    logic signed [20:0]   z_round;
    logic signed [17:0]   heading;
    logic signed [18:0]   alpha_raw;
    logic signed [16:0]   alpha_next;
    logic [31:0]          dx_abs;
    logic [31:0]          dy_abs;
    logic                 s3_vld_reg;
    logic [1:0]           s3_func_reg;
    logic                 s3_near_reg;
    logic [31:0]          s3_r_reg;
    logic signed [16:0]   s3_alpha_reg;
    logic signed [31:0]   s3_dx_reg;
    logic signed [31:0]   s3_dy_reg;
    logic [30:0]          s3_ax_reg;
    logic [30:0]          s3_ay_reg;

    // product stage
    logic               s4_vld_reg;
    logic [1:0]         s4_func_reg;
    logic               s4_near_reg;
    logic [31:0]        s4_r_reg;
    logic signed [16:0] s4_alpha_reg;
    logic signed [48:0] s4_prod_rot_reg;
    logic [62:0]        s4_prod_v_reg;
    logic signed [63:0] s4_prod_x_reg;
    logic signed [63:0] s4_prod_y_reg;
    logic [61:0]        s4_num_x_reg;
    logic [61:0]        s4_num_y_reg;
    logic               s4_neg_x_reg;
    logic               s4_neg_y_reg;

    // command selection
    logic signed [48:0] rot_sum;
    logic signed [35:0] rot_full;
    logic signed [35:0] lim36;
    logic signed [31:0] lim32;
    logic signed [31:0] rot_clamp;
    logic [63:0]        v_sum;
    logic [47:0]        total;
    logic signed [63:0] x_sum;
    logic signed [63:0] y_sum;
    logic signed [47:0] x_round;
    logic signed [47:0] y_round;
    logic signed [31:0] vx_near;
    logic signed [31:0] vy_near;
    logic               over_limit;
    ggvc_pkg::ggvc_div_t div_in;

    ggvc_pkg::ggvc_div_t div_link [0:ggvc_pkg::DIV_CELLS];
    logic                div_vld  [0:ggvc_pkg::DIV_CELLS];

    // output register
    ggvc_pkg::ggvc_div_t last_div;
    ggvc_pkg::ggvc_out_t out_next;
    logic                out_valid_reg;
    ggvc_pkg::ggvc_out_t out_data_reg;

    function automatic logic signed [31:0] sat_disp(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647)
        begin
            r = 32'sd2147483647;
        end
        else if (v < -34'sd2147483647)
        begin
            r = -32'sd2147483647;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sd2147483647)
        begin
            r = 32'sh7fffffff;
        end
        else if (v < -48'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // handshake
    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg      <= '0;
            goal_y_reg      <= '0;
            arrive_reg      <= ggvc_pkg::ARRIVE_RESET;
            speed_gain_reg  <= ggvc_pkg::UNIT_RESET;
            turn_gain_reg   <= ggvc_pkg::UNIT_RESET;
            speed_limit_reg <= ggvc_pkg::UNIT_RESET;
            turn_limit_reg  <= ggvc_pkg::UNIT_RESET;
            mode_reg        <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ggvc_pkg::CFG_GOAL_X:      goal_x_reg      <= cfg_data;
                ggvc_pkg::CFG_GOAL_Y:      goal_y_reg      <= cfg_data;
                ggvc_pkg::CFG_ARRIVE:      arrive_reg      <= cfg_data[30:0];
                ggvc_pkg::CFG_SPEED_GAIN:  speed_gain_reg  <= cfg_data[30:0];
                ggvc_pkg::CFG_TURN_GAIN:   turn_gain_reg   <= cfg_data[30:0];
                ggvc_pkg::CFG_SPEED_LIMIT: speed_limit_reg <= cfg_data[30:0];
                ggvc_pkg::CFG_TURN_LIMIT:  turn_limit_reg  <= cfg_data[30:0];
                ggvc_pkg::CFG_MODE:        mode_reg        <= cfg_data[1:0];
                default:                   mode_reg        <= mode_reg;
            endcase
        end
    end

    // origin latch on start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end
        else if (accept && in_data.func == ggvc_pkg::FUNC_START)
        begin
            if (mode_reg[ggvc_pkg::MODE_RELATIVE])
            begin
                origin_x_reg <= in_data.pose_x;
                origin_y_reg <= in_data.pose_y;
            end
            else
            begin
                origin_x_reg <= '0;
                origin_y_reg <= '0;
            end
        end
    end

    // displacement to the goal
    assign diff_x = {{2{origin_x_reg[31]}}, origin_x_reg} + {{2{goal_x_reg[31]}}, goal_x_reg}
                  - {{2{in_data.pose_x[31]}}, in_data.pose_x};
    assign diff_y = {{2{origin_y_reg[31]}}, origin_y_reg} + {{2{goal_y_reg[31]}}, goal_y_reg}
                  - {{2{in_data.pose_y[31]}}, in_data.pose_y};

    // squares and cordic pre-rotation inputs
    assign dx35  = {{3{s0_dx_reg[31]}}, s0_dx_reg};
    assign dy35  = {{3{s0_dy_reg[31]}}, s0_dy_reg};
    assign s0_ax = s0_dx_reg[31] ? -s0_dx_reg : s0_dx_reg;
    assign s0_ay = s0_dy_reg[31] ? -s0_dy_reg : s0_dy_reg;

    // front stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_vld_reg <= accept && (in_data.func == ggvc_pkg::FUNC_START
                                  || in_data.func == ggvc_pkg::FUNC_STEP
                                  || in_data.func == ggvc_pkg::FUNC_STOP);
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    // front stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_func_reg <= in_data.func;
            s0_th_reg   <= in_data.pose_heading;
            s0_dx_reg   <= sat_disp(diff_x);
            s0_dy_reg   <= sat_disp(diff_y);

            s1_sqx_reg  <= s0_ax[30:0] * s0_ax[30:0];
            s1_sqy_reg  <= s0_ay[30:0] * s0_ay[30:0];
            s1_cx_reg   <= s0_dx_reg[31] ? -dx35 : dx35;
            s1_cy_reg   <= s0_dx_reg[31] ? -dy35 : dy35;
            s1_cz_reg   <= s0_dx_reg[31] ? ggvc_pkg::PI_U16 : 21'sd0;
            s1_zero_reg <= (s0_dx_reg == 32'sd0) && (s0_dy_reg == 32'sd0);
            s1_func_reg <= s0_func_reg;
            s1_th_reg   <= s0_th_reg;
            s1_dx_reg   <= s0_dx_reg;
            s1_dy_reg   <= s0_dy_reg;

            s2_cell_reg.rem  <= {1'b0, s1_sqx_reg} + {1'b0, s1_sqy_reg};
            s2_cell_reg.root <= '0;
            s2_cell_reg.cx   <= s1_cx_reg;
            s2_cell_reg.cy   <= s1_cy_reg;
            s2_cell_reg.cz   <= s1_cz_reg;
            s2_cell_reg.zero <= s1_zero_reg;
            s2_cell_reg.func <= s1_func_reg;
            s2_cell_reg.th   <= s1_th_reg;
            s2_cell_reg.dx   <= s1_dx_reg;
            s2_cell_reg.dy   <= s1_dy_reg;
        end
    end

    // sqrt and cordic chain
    assign cell_link[0] = s2_cell_reg;
    assign cell_vld[0]  = s2_vld_reg;

    for (genvar gi = 0; gi < ggvc_pkg::SQRT_CELLS; gi++)
    begin : g_cell
        ggvc_cell #(
            .IDX       (gi),
            .CORDIC_ON (gi < CORDIC_STAGES)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .in_vld   (cell_vld[gi]),
            .in_cell  (cell_link[gi]),
            .out_vld  (cell_vld[gi + 1]),
            .out_cell (cell_link[gi + 1])
        );
    end

    // heading error, wrapped once into plus or minus pi
    assign last_cell = cell_link[ggvc_pkg::SQRT_CELLS];
    assign z_round   = last_cell.cz + 21'sd4;
    assign heading   = last_cell.zero ? 18'sd0 : z_round[20:3];
    assign alpha_raw = {heading[17], heading} - {{3{last_cell.th[15]}}, last_cell.th};
    assign dx_abs    = last_cell.dx[31] ? -last_cell.dx : last_cell.dx;
    assign dy_abs    = last_cell.dy[31] ? -last_cell.dy : last_cell.dy;

    always_comb
    begin
        if (alpha_raw > ggvc_pkg::PI_Q13)
        begin
            alpha_next = 17'(alpha_raw - ggvc_pkg::TWO_PI_Q13);
        end
        else if (alpha_raw < -ggvc_pkg::PI_Q13)
        begin
            alpha_next = 17'(alpha_raw + ggvc_pkg::TWO_PI_Q13);
        end
        else
        begin
            alpha_next = alpha_raw[16:0];
        end
    end

    // back stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_vld_reg <= cell_vld[ggvc_pkg::SQRT_CELLS];
            s4_vld_reg <= s3_vld_reg;
        end
    end

    // error, distance and product stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_func_reg  <= last_cell.func;
            s3_near_reg  <= last_cell.root[31:0] < {1'b0, arrive_reg};
            s3_r_reg     <= last_cell.root[31:0];
            s3_alpha_reg <= alpha_next;
            s3_dx_reg    <= last_cell.dx;
            s3_dy_reg    <= last_cell.dy;
            s3_ax_reg    <= dx_abs[30:0];
            s3_ay_reg    <= dy_abs[30:0];

            s4_func_reg     <= s3_func_reg;
            s4_near_reg     <= s3_near_reg;
            s4_r_reg        <= s3_r_reg;
            s4_alpha_reg    <= s3_alpha_reg;
            s4_prod_rot_reg <= $signed({1'b0, turn_gain_reg}) * s3_alpha_reg;
            s4_prod_v_reg   <= speed_gain_reg * s3_r_reg;
            s4_prod_x_reg   <= $signed({1'b0, speed_gain_reg}) * s3_dx_reg;
            s4_prod_y_reg   <= $signed({1'b0, speed_gain_reg}) * s3_dy_reg;
            s4_num_x_reg    <= s3_ax_reg * speed_limit_reg;
            s4_num_y_reg    <= s3_ay_reg * speed_limit_reg;
            s4_neg_x_reg    <= s3_dx_reg[31];
            s4_neg_y_reg    <= s3_dy_reg[31];
        end
    end

    // rounding and limits
    assign rot_sum  = s4_prod_rot_reg + 49'sd4096;
    assign rot_full = rot_sum[48:13];
    assign lim36    = $signed({5'b0, turn_limit_reg});
    assign lim32    = $signed({1'b0, turn_limit_reg});
    assign v_sum    = {1'b0, s4_prod_v_reg} + 64'd32768;
    assign total    = v_sum[63:16];
    assign x_sum    = s4_prod_x_reg + 64'sd32768;
    assign y_sum    = s4_prod_y_reg + 64'sd32768;
    assign x_round  = x_sum[63:16];
    assign y_round  = y_sum[63:16];
    assign vx_near  = sat48(x_round);
    assign vy_near  = sat48(y_round);
    assign over_limit = total > {17'd0, speed_limit_reg};

    always_comb
    begin
        if (rot_full > lim36)
        begin
            rot_clamp = lim32;
        end
        else if (rot_full < -lim36)
        begin
            rot_clamp = -lim32;
        end
        else
        begin
            rot_clamp = rot_full[31:0];
        end
    end

    // command selection and divide chain entry
    always_comb
    begin
        div_in       = '0;
        div_in.d     = s4_r_reg;
        div_in.rem_x = {1'b0, s4_num_x_reg[61:31]};
        div_in.low_x = s4_num_x_reg[30:0];
        div_in.rem_y = {1'b0, s4_num_y_reg[61:31]};
        div_in.low_y = s4_num_y_reg[30:0];
        div_in.res.neg_x = s4_neg_x_reg;
        div_in.res.neg_y = s4_neg_y_reg;
        case (s4_func_reg)
            ggvc_pkg::FUNC_START:
            begin
                div_in.res.status = ggvc_pkg::STATUS_INIT;
            end
            ggvc_pkg::FUNC_STOP:
            begin
                div_in.res.status    = ggvc_pkg::STATUS_TERMINATED;
                div_in.res.cmd_valid = 1'b1;
            end
            ggvc_pkg::FUNC_STEP:
            begin
                if (s4_near_reg)
                begin
                    div_in.res.status = ggvc_pkg::STATUS_COMPLETED;
                end
                else if (mode_reg[ggvc_pkg::MODE_HOLONOMIC])
                begin
                    div_in.res.status     = ggvc_pkg::STATUS_RUNNING;
                    div_in.res.cmd_valid  = 1'b1;
                    div_in.res.cmd_planar = 1'b1;
                    div_in.res.rot        = rot_clamp;
                    div_in.res.use_div    = over_limit && (s4_r_reg != 32'd0);
                    div_in.res.vx         = vx_near;
                    div_in.res.vy         = vy_near;
                end
                else if (s4_alpha_reg > ggvc_pkg::TURN_THRESH_Q13
                      || s4_alpha_reg < -ggvc_pkg::TURN_THRESH_Q13)
                begin
                    div_in.res.status    = ggvc_pkg::STATUS_RUNNING;
                    div_in.res.cmd_valid = 1'b1;
                    div_in.res.rot       = s4_alpha_reg[16] ? -lim32 : lim32;
                end
                else
                begin
                    div_in.res.status    = ggvc_pkg::STATUS_RUNNING;
                    div_in.res.cmd_valid = 1'b1;
                    div_in.res.rot       = rot_clamp;
                    div_in.res.vx        = over_limit ? $signed({1'b0, speed_limit_reg})
                                                      : $signed(total[31:0]);
                end
            end
            default:
            begin
                div_in.res.status = ggvc_pkg::STATUS_INIT;
            end
        endcase
    end

    // divide chain for the speed-limited planar command
    assign div_link[0] = div_in;
    assign div_vld[0]  = s4_vld_reg;

    for (genvar gd = 0; gd < ggvc_pkg::DIV_CELLS; gd++)
    begin : g_div
        ggvc_div_cell u_div_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .in_vld  (div_vld[gd]),
            .in_div  (div_link[gd]),
            .out_vld (div_vld[gd + 1]),
            .out_div (div_link[gd + 1])
        );
    end

    // result assembly
    assign last_div = div_link[ggvc_pkg::DIV_CELLS];

    always_comb
    begin
        out_next.status     = last_div.res.status;
        out_next.cmd_valid  = last_div.res.cmd_valid;
        out_next.cmd_planar = last_div.res.cmd_planar;
        out_next.turn_rate  = last_div.res.rot;
        if (last_div.res.use_div)
        begin
            out_next.vel_fwd_x  = last_div.res.neg_x ? -$signed({1'b0, last_div.q_x})
                                                     : $signed({1'b0, last_div.q_x});
            out_next.vel_side_y = last_div.res.neg_y ? -$signed({1'b0, last_div.q_y})
                                                     : $signed({1'b0, last_div.q_y});
        end
        else
        begin
            out_next.vel_fwd_x  = last_div.res.vx;
            out_next.vel_side_y = last_div.res.vy;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= div_vld[ggvc_pkg::DIV_CELLS];
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // relative start latches the pose as origin
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.func == ggvc_pkg::FUNC_START && mode_reg[ggvc_pkg::MODE_RELATIVE])
        |=> (origin_x_reg == $past(in_data.pose_x) && origin_y_reg == $past(in_data.pose_y)))
        else $error("origin not latched on relative start");

    // rotation never exceeds the turn limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.turn_rate <= $signed({1'b0, turn_limit_reg})
                    && out_data.turn_rate >= -$signed({1'b0, turn_limit_reg})))
        else $error("turn rate beyond limit");

    // a completed result carries no command
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == ggvc_pkg::STATUS_COMPLETED)
        |-> (!out_data.cmd_valid && out_data.vel_fwd_x == 32'sd0
          && out_data.turn_rate == 32'sd0))
        else $error("completed result with command");
`endif

endmodule

### dv/ggvc_checker.sv
// checker: predicts controller results from accepted requests and compares them
module ggvc_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  ggvc_pkg::ggvc_in_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  ggvc_pkg::ggvc_out_t out_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STAGES = 16;
    localparam longint SAT32 = 64'sd2147483647;

    // arctangent of 2^-i, units of 2^-16 rad
    localparam longint ARCTAN [0:16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
        512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

    // controller settings and latched origin
    longint goal_x, goal_y, origin_x, origin_y;
    longint arrive, speed_gain, turn_gain, speed_lim, turn_lim;
    logic [1:0] mode;

    ggvc_pkg::ggvc_out_t cmd_q[$];

    function automatic longint clip(longint v, longint lo, longint hi);
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return longint'(root);
    endfunction

    // vectoring cordic, result in Q3.13
    function automatic longint bearing(longint dx, longint dy);
        longint x, y, z, nx;
        if (dx == 0 && dy == 0)
            return 0;
        x = dx;
        y = dy;
        z = 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 205887;
        end
        for (int i = 0; i < STAGES; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ARCTAN[i];
            end
            else
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ARCTAN[i];
            end
            x = nx;
        end
        return (z + 4) >>> 3;
    endfunction

    // velocity command for one request; returns 0 when the request is ignored
    function automatic bit control_cmd(input ggvc_pkg::ggvc_in_t req,
                                       output ggvc_pkg::ggvc_out_t cmd);
        longint dx, dy, r, alpha, rot, total, vx, vy;
        cmd = '0;
        if (req.func == ggvc_pkg::FUNC_START)
        begin
            origin_x = mode[ggvc_pkg::MODE_RELATIVE] ? longint'(req.pose_x) : 0;
            origin_y = mode[ggvc_pkg::MODE_RELATIVE] ? longint'(req.pose_y) : 0;
            cmd.status = ggvc_pkg::STATUS_INIT;
            return 1;
        end
        if (req.func == ggvc_pkg::FUNC_STOP)
        begin
            cmd.status = ggvc_pkg::STATUS_TERMINATED;
            cmd.cmd_valid = 1'b1;
            return 1;
        end
        if (req.func != ggvc_pkg::FUNC_STEP)
            return 0;
        dx = clip(origin_x + goal_x - longint'(req.pose_x), -SAT32, SAT32);
        dy = clip(origin_y + goal_y - longint'(req.pose_y), -SAT32, SAT32);
        r = int_sqrt(longint'(dx * dx) + longint'(dy * dy));
        if (r < arrive)
        begin
            cmd.status = ggvc_pkg::STATUS_COMPLETED;
            return 1;
        end
        alpha = bearing(dx, dy) - longint'(req.pose_heading);
        while (alpha > 25736) alpha = alpha - 51472;
        while (alpha < -25736) alpha = alpha + 51472;
        rot = clip((turn_gain * alpha + 4096) >>> 13, -turn_lim, turn_lim);
        cmd.status = ggvc_pkg::STATUS_RUNNING;
        cmd.cmd_valid = 1'b1;
        total = (speed_gain * r + 32768) >>> 16;
        if (mode[ggvc_pkg::MODE_HOLONOMIC])
        begin
            if (total > speed_lim && r > 0)
            begin
                vx = dx * speed_lim / r;
                vy = dy * speed_lim / r;
            end
            else
            begin
                vx = (speed_gain * dx + 32768) >>> 16;
                vy = (speed_gain * dy + 32768) >>> 16;
            end
            cmd.cmd_planar = 1'b1;
            cmd.vel_fwd_x = 32'(clip(vx, -SAT32 - 1, SAT32));
            cmd.vel_side_y = 32'(clip(vy, -SAT32 - 1, SAT32));
            cmd.turn_rate = 32'(rot);
        end
        else if (alpha > 2859 || alpha < -2859)
            cmd.turn_rate = 32'(alpha > 0 ? turn_lim : -turn_lim);
        else
        begin
            cmd.vel_fwd_x = 32'(total > speed_lim ? speed_lim : total);
            cmd.turn_rate = 32'(rot);
        end
        return 1;
    endfunction

    assign pending = cmd_q.size();

    // watch the three channels
    always @(posedge clk or negedge rst_n)
    begin
        ggvc_pkg::ggvc_out_t want;
        if (!rst_n)
        begin
            goal_x = 0;
            goal_y = 0;
            arrive = 6554;
            speed_gain = 65536;
            turn_gain = 65536;
            speed_lim = 65536;
            turn_lim = 65536;
            mode = 2'd0;
            origin_x = 0;
            origin_y = 0;
            fail_count = 0;
            cmd_q.delete();
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ggvc_pkg::CFG_GOAL_X:      goal_x = longint'(signed'(cfg_data));
                    ggvc_pkg::CFG_GOAL_Y:      goal_y = longint'(signed'(cfg_data));
                    ggvc_pkg::CFG_ARRIVE:      arrive = longint'(cfg_data[30:0]);
                    ggvc_pkg::CFG_SPEED_GAIN:  speed_gain = longint'(cfg_data[30:0]);
                    ggvc_pkg::CFG_TURN_GAIN:   turn_gain = longint'(cfg_data[30:0]);
                    ggvc_pkg::CFG_SPEED_LIMIT: speed_lim = longint'(cfg_data[30:0]);
                    ggvc_pkg::CFG_TURN_LIMIT:  turn_lim = longint'(cfg_data[30:0]);
                    ggvc_pkg::CFG_MODE:        mode = cfg_data[1:0];
                    default:                   ;
                endcase
            end
            // accepted request
            if (in_valid && in_ready)
            begin
                if (control_cmd(in_data, want))
                    cmd_q.push_back(want);
            end
            // accepted result
            if (out_valid && out_ready)
            begin
                if (cmd_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %p", out_data);
                end
                else
                begin
                    want = cmd_q.pop_front();
                    if (out_data.status !== want.status
                        || out_data.cmd_valid !== want.cmd_valid
                        || out_data.cmd_planar !== want.cmd_planar
                        || out_data.vel_fwd_x !== want.vel_fwd_x
                        || out_data.vel_side_y !== want.vel_side_y
                        || out_data.turn_rate !== want.turn_rate)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p got %p", want, out_data);
                    end
                end
            end
        end
    end

endmodule

### dv/go_to_goal_velocity_control_unit_tb.sv
// testbench top: drives requests and settings into the controller and gives the verdict
module go_to_goal_velocity_control_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES = 7;
    localparam int PHASE_ITEMS = 172;
    localparam int DRAIN = 80;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    ggvc_pkg::ggvc_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    ggvc_pkg::ggvc_out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int fail_count;
    int pending;

    int send_idle = 10;
    int recv_idle = 71;
    int sent = 0;
    // target point as seen by the stimulus, used to aim poses near the goal
    longint aim_x, aim_y, goal_x, goal_y;
    logic [1:0] mode;

    go_to_goal_velocity_control_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ggvc_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    // timeout
    initial
    begin
        #10ms;
        $display("tb: failure");
        $finish;
    end

    task automatic send_request(logic [1:0] func, logic [31:0] px, logic [31:0] py,
                                logic [15:0] hd);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{func: func, pose_x: px, pose_y: py, pose_heading: hd};
        do @(posedge clk); while (!in_ready);
        sent++;
        if (sent == 400)
        begin
            send_idle = 71;
            recv_idle = 10;
        end
        else if (sent == 800)
        begin
            send_idle = 0;
            recv_idle = 0;
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            ggvc_pkg::CFG_GOAL_X: goal_x = longint'(signed'(val));
            ggvc_pkg::CFG_GOAL_Y: goal_y = longint'(signed'(val));
            ggvc_pkg::CFG_MODE:   mode = val[1:0];
            default:    ;
        endcase
    endtask

    // wait for the pipeline to empty before touching the settings
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    function automatic logic [15:0] any_heading();
        return 16'($signed($urandom_range(51472)) - 25736);
    endfunction

    // pose coordinate near the aim point at a random scale, or a fully random one
    function automatic logic [31:0] near(longint center);
        longint v;
        case ($urandom_range(3))
            0: v = center + $signed($urandom_range(16384)) - 8192;
            1: v = center + $signed($urandom_range(1 << 21)) - (1 << 20);
            2: v = center + $signed($urandom_range(1 << 27)) - (1 << 26);
            default: return $urandom;
        endcase
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    task automatic setup_phase(int p);
        logic [31:0] val [8];
        val[ggvc_pkg::CFG_GOAL_X] = $signed($urandom_range(1 << 25)) - (1 << 24);
        val[ggvc_pkg::CFG_GOAL_Y] = $signed($urandom_range(1 << 25)) - (1 << 24);
        val[ggvc_pkg::CFG_ARRIVE] = $urandom_range(1 << 18);
        val[ggvc_pkg::CFG_SPEED_GAIN] = $urandom_range(1 << 20);
        val[ggvc_pkg::CFG_TURN_GAIN] = $urandom_range(1 << 20);
        val[ggvc_pkg::CFG_SPEED_LIMIT] = $urandom_range(1 << 22);
        val[ggvc_pkg::CFG_TURN_LIMIT] = $urandom_range(1 << 19);
        val[ggvc_pkg::CFG_MODE] = p % 4;
        case (p)
            0:
            begin
                val[ggvc_pkg::CFG_GOAL_X] = 0;
                val[ggvc_pkg::CFG_GOAL_Y] = 0;
                val[ggvc_pkg::CFG_ARRIVE] = 0;
                val[ggvc_pkg::CFG_SPEED_GAIN] = 65536;
                val[ggvc_pkg::CFG_TURN_GAIN] = 65536;
                val[ggvc_pkg::CFG_SPEED_LIMIT] = 65536;
                val[ggvc_pkg::CFG_TURN_LIMIT] = 65536;
                val[ggvc_pkg::CFG_MODE] = 1;
            end
            2:
            begin
                val[ggvc_pkg::CFG_GOAL_X] = 32'h7fff_ffff;
                val[ggvc_pkg::CFG_GOAL_Y] = 32'h8000_0000;
                val[ggvc_pkg::CFG_SPEED_GAIN] = 32'hffff_ffff;
                val[ggvc_pkg::CFG_TURN_GAIN] = 32'h7fff_ffff;
                val[ggvc_pkg::CFG_SPEED_LIMIT] = 32'h7fff_ffff;
                val[ggvc_pkg::CFG_TURN_LIMIT] = 32'hffff_ffff;
                val[ggvc_pkg::CFG_MODE] = 3;
            end
            3:
            begin
                val[ggvc_pkg::CFG_ARRIVE] = 0;
                val[ggvc_pkg::CFG_SPEED_GAIN] = 0;
                val[ggvc_pkg::CFG_TURN_GAIN] = 0;
                val[ggvc_pkg::CFG_SPEED_LIMIT] = 0;
                val[ggvc_pkg::CFG_TURN_LIMIT] = 0;
                val[ggvc_pkg::CFG_MODE] = 2;
            end
            5:
            begin
                val[ggvc_pkg::CFG_ARRIVE] = 32'hffff_ffff;
                val[ggvc_pkg::CFG_MODE] = 32'hffff_fffc;
            end
            default: ;
        endcase
        for (int i = 0; i < 8; i++)
            write_reg(3'(i), val[i]);
    endtask

    // well-formed runs: start, a burst of steps, mostly a stop, with some noise
    task automatic random_phase(int count);
        int n;
        logic [31:0] px, py;
        n = 0;
        while (n < count)
        begin
            px = $urandom;
            py = $urandom;
            send_request(ggvc_pkg::FUNC_START, px, py, any_heading());
            aim_x = goal_x + (mode[ggvc_pkg::MODE_RELATIVE] ? longint'(signed'(px)) : 0);
            aim_y = goal_y + (mode[ggvc_pkg::MODE_RELATIVE] ? longint'(signed'(py)) : 0);
            n++;
            repeat ($urandom_range(12, 2))
            begin
                if ($urandom_range(19) == 0)
                    send_request(2'($urandom_range(3)), $urandom, $urandom, any_heading());
                else
                    send_request(ggvc_pkg::FUNC_STEP, near(aim_x), near(aim_y),
                                 any_heading());
                n++;
            end
            if ($urandom_range(3) != 0)
            begin
                send_request(ggvc_pkg::FUNC_STOP, $urandom, $urandom, any_heading());
                n++;
            end
        end
    endtask

    initial
    begin
        int failed;
        mode = 2'd0;
        goal_x = 0;
        goal_y = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every event, zero displacement, ignored code
        setup_phase(0);
        send_request(ggvc_pkg::FUNC_STEP, 32'd0, 32'd0, 16'd0);
        send_request(ggvc_pkg::FUNC_START, 32'h7fff_ffff, 32'h8000_0000, 16'sd25736);
        send_request(ggvc_pkg::FUNC_STEP, 32'h7fff_ffff, 32'h8000_0000, -16'sd25736);
        send_request(ggvc_pkg::FUNC_STEP, 32'h8000_0000, 32'h7fff_ffff, 16'sd25736);
        send_request(ggvc_pkg::FUNC_STEP, 32'hffff_0000, 32'd0, 16'd0);
        send_request(ggvc_pkg::FUNC_STEP, 32'h0001_0000, 32'd0, 16'd0);
        send_request(ggvc_pkg::FUNC_STEP, 32'd0, 32'h0001_0000, -16'sd12868);
        send_request(ggvc_pkg::FUNC_STEP, 32'd0, 32'hffff_0000, 16'sd12868);
        send_request(ggvc_pkg::FUNC_STEP, 32'd100, 32'd0, 16'd0);
        send_request(2'd3, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
        send_request(ggvc_pkg::FUNC_STOP, 32'h1234_5678, 32'h8765_4321, 16'd0);
        drain();
        write_reg(ggvc_pkg::CFG_MODE, 32'd0);
        write_reg(ggvc_pkg::CFG_ARRIVE, 32'd6554);
        send_request(ggvc_pkg::FUNC_STEP, 32'd0, 32'd0, 16'd0);
        send_request(ggvc_pkg::FUNC_STEP, 32'hfff0_0000, 32'd0, 16'd0);
        send_request(ggvc_pkg::FUNC_STEP, 32'hfff0_0000, 32'd0, 16'sd3000);
        send_request(ggvc_pkg::FUNC_STEP, 32'hfff0_0000, 32'd0, -16'sd3000);
        send_request(ggvc_pkg::FUNC_STEP, 32'hfff0_0000, 32'd0, 16'sd2859);
        send_request(ggvc_pkg::FUNC_STEP, 32'h0010_0000, 32'd0, 16'sd25736);
        send_request(ggvc_pkg::FUNC_STEP, 32'h0010_0000, 32'd0, -16'sd25736);
        drain();
        write_reg(ggvc_pkg::CFG_MODE, 32'd2);
        send_request(ggvc_pkg::FUNC_START, 32'h0005_0000, 32'hfffb_0000, 16'd0);
        send_request(ggvc_pkg::FUNC_STEP, 32'd0, 32'd0, 16'd0);
        send_request(ggvc_pkg::FUNC_STEP, 32'h0005_0000, 32'hfffb_0000, 16'd0);
        random_phase(PHASE_ITEMS - 20);

        for (int p = 1; p < PHASES; p++)
        begin
            drain();
            setup_phase(p);
            random_phase(PHASE_ITEMS);
        end

        drain();
        failed = fail_count + pending;
        if (failed == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### files.f
design/ggvc_pkg.sv
design/ggvc_cell.sv
design/ggvc_div_cell.sv
design/go_to_goal_velocity_control_unit.sv
dv/ggvc_checker.sv
dv/go_to_goal_velocity_control_unit_tb.sv
